// ===== rtl/ccs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared constants, command codes and controller/datapath interface types
// for the circle collision search core.
// ----------------------------------------------------------------------------
package ccs_pkg;

    localparam int CCS_MAX_ENTITIES = 256;

    localparam int COMMAND_W   = 2;
    localparam int SLOT_W      = 8;
    localparam int POSITION_W  = 8;
    localparam int COORD_W     = 16;
    localparam int ERADIUS_W   = 8;
    localparam int QRADIUS_W   = 12;
    localparam int COUNT_IN_W  = 9;

    typedef enum logic [COMMAND_W-1:0] {
        CMD_WR_ENTITY = 2'd0,
        CMD_WR_LIST   = 2'd1,
        CMD_QUERY     = 2'd2,
        CMD_NONE      = 2'd3
    } ccs_command_t;

    typedef struct packed {
        logic wr_entity;
        logic wr_list;
        logic start;
        logic run;
        logic finish;
        logic load_out;
    } ccs_cmd_t;

    typedef struct packed {
        logic more;
        logic busy;
        logic hit_now;
    } ccs_status_t;

endpackage
`default_nettype wire

// ===== rtl/ccs_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccs_controller
// Sequencer for table writes and queries; owns the handshakes and the
// output valid flag.
// ----------------------------------------------------------------------------
module ccs_controller
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [ccs_pkg::COMMAND_W-1:0]  command,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    input  wire ccs_pkg::ccs_status_t           status,
    output ccs_pkg::ccs_cmd_t                   cmd
);
    import ccs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid & in_ready;
    assign out_free  = ~out_valid_reg | out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        cmd            = '0;
        cmd.wr_entity  = accept & (command == CMD_WR_ENTITY);
        cmd.wr_list    = accept & (command == CMD_WR_LIST);
        cmd.start      = accept & (command == CMD_QUERY);
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.run = 1'b1;
                if (status.hit_now | (~status.more & ~status.busy))
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ccs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccs_datapath
// Entity table, active list, index counter and the compare pipeline:
// list read, table read, differences, squares, distance compare.
// ----------------------------------------------------------------------------
module ccs_datapath
#(
    parameter int MAX_ENTITIES = ccs_pkg::CCS_MAX_ENTITIES
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire ccs_pkg::ccs_cmd_t                     cmd,
    output ccs_pkg::ccs_status_t                       status,
    input  wire logic        [ccs_pkg::SLOT_W-1:0]     slot,
    input  wire logic        [ccs_pkg::POSITION_W-1:0] list_position,
    input  wire logic signed [ccs_pkg::COORD_W-1:0]    coord_x,
    input  wire logic signed [ccs_pkg::COORD_W-1:0]    coord_y,
    input  wire logic        [ccs_pkg::ERADIUS_W-1:0]  entity_radius_in,
    input  wire logic        [ccs_pkg::QRADIUS_W-1:0]  query_radius,
    input  wire logic        [ccs_pkg::COUNT_IN_W-1:0] active_count,
    output logic                                       hit,
    output logic             [ccs_pkg::SLOT_W-1:0]     hit_slot
);
    import ccs_pkg::*;

    localparam int IDX_W   = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
    localparam int CNT_RAW = $clog2(MAX_ENTITIES + 1);
    localparam int CNT_W   = (CNT_RAW > COUNT_IN_W) ? CNT_RAW : COUNT_IN_W;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int RSUM_W  = QRADIUS_W + 1;
    localparam int RR_W    = 2 * RSUM_W;
    localparam int DIST_W  = SQ_W + 1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [ERADIUS_W-1:0]      r;
    } entity_t;

    entity_t              ent_mem [MAX_ENTITIES];
    logic [SLOT_W-1:0]    list_mem [MAX_ENTITIES];

    logic [CNT_W-1:0]          idx_reg;
    logic [CNT_W-1:0]          count_reg;
    logic signed [COORD_W-1:0] qx_reg;
    logic signed [COORD_W-1:0] qy_reg;
    logic [QRADIUS_W-1:0]      qr_reg;

    logic                      p1_valid_reg;
    logic [SLOT_W-1:0]         p1_slot_reg;
    logic                      p2_valid_reg;
    logic [SLOT_W-1:0]         p2_slot_reg;
    entity_t                   p2_ent_reg;
    logic                      p3_valid_reg;
    logic [SLOT_W-1:0]         p3_slot_reg;
    logic signed [DIFF_W-1:0]  p3_dx_reg;
    logic signed [DIFF_W-1:0]  p3_dy_reg;
    logic [RSUM_W-1:0]         p3_rsum_reg;
    logic                      p4_valid_reg;
    logic [SLOT_W-1:0]         p4_slot_reg;
    logic [SQ_W-1:0]           p4_dx2_reg;
    logic [SQ_W-1:0]           p4_dy2_reg;
    logic [RR_W-1:0]           p4_rr_reg;

    logic                      res_hit_reg;
    logic [SLOT_W-1:0]         res_slot_reg;
    logic                      out_hit_reg;
    logic [SLOT_W-1:0]         out_slot_reg;

    logic [CNT_W-1:0]          count_in;
    logic [CNT_W-1:0]          count_sat;
    logic                      issue;
    logic                      p1_in_range;
    logic signed [2*DIFF_W-1:0] dx_sq;
    logic signed [2*DIFF_W-1:0] dy_sq;
    logic [RR_W-1:0]           rr;
    logic [DIST_W-1:0]         dist_sum;
    logic                      hit_now;

    assign count_in    = CNT_W'(active_count);
    assign count_sat   = (count_in > CNT_W'(MAX_ENTITIES)) ? CNT_W'(MAX_ENTITIES) : count_in;
    assign issue       = cmd.run & (idx_reg < count_reg);
    assign p1_in_range = (32'(p1_slot_reg) < MAX_ENTITIES);
    assign dx_sq       = (2*DIFF_W)'(p3_dx_reg) * (2*DIFF_W)'(p3_dx_reg);
    assign dy_sq       = (2*DIFF_W)'(p3_dy_reg) * (2*DIFF_W)'(p3_dy_reg);
    assign rr          = RR_W'(p3_rsum_reg) * RR_W'(p3_rsum_reg);
    assign dist_sum    = DIST_W'(p4_dx2_reg) + DIST_W'(p4_dy2_reg);
    assign hit_now     = p4_valid_reg & (dist_sum <= DIST_W'(p4_rr_reg));

    assign status = '{
        more:    (idx_reg < count_reg),
        busy:    p1_valid_reg | p2_valid_reg | p3_valid_reg | p4_valid_reg,
        hit_now: hit_now
    };

    assign hit      = out_hit_reg;
    assign hit_slot = out_slot_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_entity && (32'(slot) < MAX_ENTITIES))
        begin
            ent_mem[IDX_W'(slot)] <= '{x: coord_x, y: coord_y, r: entity_radius_in};
        end
        p2_ent_reg <= ent_mem[IDX_W'(p1_slot_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_list && (32'(list_position) < MAX_ENTITIES))
        begin
            list_mem[IDX_W'(list_position)] <= slot;
        end
        if (issue)
        begin
            p1_slot_reg <= list_mem[IDX_W'(idx_reg)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            count_reg    <= '0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                idx_reg   <= '0;
                count_reg <= count_sat;
            end
            else if (issue)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            p1_valid_reg <= issue;
            p2_valid_reg <= cmd.run & p1_valid_reg & p1_in_range;
            p3_valid_reg <= cmd.run & p2_valid_reg;
            p4_valid_reg <= cmd.run & p3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            qx_reg <= coord_x;
            qy_reg <= coord_y;
            qr_reg <= query_radius;
        end
        p2_slot_reg <= p1_slot_reg;
        p3_slot_reg <= p2_slot_reg;
        p3_dx_reg   <= DIFF_W'(qx_reg) - DIFF_W'(p2_ent_reg.x);
        p3_dy_reg   <= DIFF_W'(qy_reg) - DIFF_W'(p2_ent_reg.y);
        p3_rsum_reg <= RSUM_W'(qr_reg) + RSUM_W'(p2_ent_reg.r);
        p4_slot_reg <= p3_slot_reg;
        p4_dx2_reg  <= dx_sq[SQ_W-1:0];
        p4_dy2_reg  <= dy_sq[SQ_W-1:0];
        p4_rr_reg   <= rr;
        if (cmd.finish)
        begin
            res_hit_reg  <= hit_now;
            res_slot_reg <= hit_now ? p4_slot_reg : '0;
        end
        if (cmd.load_out)
        begin
            out_hit_reg  <= res_hit_reg;
            out_slot_reg <= res_slot_reg;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/circle_collision_search_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// circle_collision_search_core
// Entity table with an ordered active list and a first-hit circle search.
// ----------------------------------------------------------------------------
// Entity and active-list writes give no result. A query walks its
// min(active_count, MAX_ENTITIES) active entries in list order, one entry
// entering the compare pipeline per cycle (list memory read, table memory
// read, coordinate differences, squares, compare); it stops early when an
// entry hits, and its result may wait for the previous result to leave the
// output register; the input is closed while a query runs. The result sits
// in an output register, so a new item may be taken while it waits. The
// memories have no reset: a query that reads an entry never written returns
// an undefined answer.
// ----------------------------------------------------------------------------
module circle_collision_search_core
#(
    parameter int MAX_ENTITIES = ccs_pkg::CCS_MAX_ENTITIES
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic        [ccs_pkg::COMMAND_W-1:0]  command,
    input  wire logic        [ccs_pkg::SLOT_W-1:0]     slot,
    input  wire logic        [ccs_pkg::POSITION_W-1:0] list_position,
    input  wire logic signed [ccs_pkg::COORD_W-1:0]    coord_x,
    input  wire logic signed [ccs_pkg::COORD_W-1:0]    coord_y,
    input  wire logic        [ccs_pkg::ERADIUS_W-1:0]  entity_radius_in,
    input  wire logic        [ccs_pkg::QRADIUS_W-1:0]  query_radius,
    input  wire logic        [ccs_pkg::COUNT_IN_W-1:0] active_count,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic                                       hit,
    output logic             [ccs_pkg::SLOT_W-1:0]     hit_slot
);
    import ccs_pkg::*;

    ccs_cmd_t    cmd;
    ccs_status_t status;

    ccs_controller u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ccs_datapath
    #(
        .MAX_ENTITIES (MAX_ENTITIES)
    )
    u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .slot             (slot),
        .list_position    (list_position),
        .coord_x          (coord_x),
        .coord_y          (coord_y),
        .entity_radius_in (entity_radius_in),
        .query_radius     (query_radius),
        .active_count     (active_count),
        .hit              (hit),
        .hit_slot         (hit_slot)
    );

endmodule
`default_nettype wire

// ===== rtl/ccs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccs_checker
// Port-level checks for the circle collision search core.
// ----------------------------------------------------------------------------
module ccs_checker
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic [ccs_pkg::COMMAND_W-1:0] command,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic                          hit,
    input wire logic [ccs_pkg::SLOT_W-1:0]    hit_slot
);
    import ccs_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(hit_slot))
        else $error("result changed while stalled");

    a_miss_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> hit_slot == '0)
        else $error("miss result carries a nonzero slot");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command == CMD_QUERY |=> !in_ready)
        else $error("input open right after a query transfer");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without a running query");

endmodule

bind circle_collision_search_core ccs_checker u_ccs_checker (.*);
`default_nettype wire
